### hdl/semaphore_table_wait_queue_assert.svh
// Assertion helpers shared by the semaphore table RTL.
// Both expect a signal named clk, and STWQ_ASSERT also one named rst_n, in the scope where they are used.
`ifndef SEMAPHORE_TABLE_WAIT_QUEUE_ASSERT_SVH
`define SEMAPHORE_TABLE_WAIT_QUEUE_ASSERT_SVH

// Checked only while reset is released.
`define STWQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define STWQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/stwq_pkg.sv
`default_nettype none

package stwq_pkg;

    localparam int SEM_COUNT   = 16;
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;

    // Caller ids arrive on an 8-bit field, so at most 8 bits are ever kept.
    localparam int CID_W      = (ID_BITS < 8) ? ID_BITS : 8;
    localparam int SLOT_W     = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
    localparam int HEAD_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int WAIT_DEPTH = SEM_COUNT * QUEUE_DEPTH;
    localparam int WAIT_AW    = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;

    typedef enum logic [1:0] {
        FN_ALLOC = 2'd0,
        FN_FREE  = 2'd1,
        FN_DOWN  = 2'd2,
        FN_UP    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_INDEX  = 3'd1,
        ST_NOT_OWNER  = 3'd2,
        ST_TALLY      = 3'd3,
        ST_NONE_FREE  = 3'd4,
        ST_QUEUE_FULL = 3'd5
    } status_t;

    // One semaphore slot as it is held in the slot memory.
    typedef struct packed {
        logic [CID_W-1:0]   owner;
        logic signed [15:0] count;
        logic [31:0]        up_tally;
        logic [31:0]        down_tally;
        logic [HEAD_W-1:0]  head;
    } slot_t;

endpackage

`default_nettype wire

### hdl/stwq_req_if.sv
`default_nettype none

interface stwq_req_if import stwq_pkg::*;;
    logic               valid;
    logic               ready;
    func_t              func;
    logic [3:0]         sem_index;
    logic signed [15:0] initial_value;
    logic [7:0]         caller_id;

    modport source (output valid, output func, output sem_index, output initial_value,
                    output caller_id, input ready);
    modport sink   (input valid, input func, input sem_index, input initial_value,
                    input caller_id, output ready);
endinterface

`default_nettype wire

### hdl/stwq_rsp_if.sv
`default_nettype none

interface stwq_rsp_if import stwq_pkg::*;;
    logic       valid;
    logic       ready;
    status_t    status;
    logic [3:0] granted_index;
    logic       caller_blocked;
    logic       woken_valid;
    logic [7:0] woken_id;

    modport source (output valid, output status, output granted_index, output caller_blocked,
                    output woken_valid, output woken_id, input ready);
    modport sink   (input valid, input status, input granted_index, input caller_blocked,
                    input woken_valid, input woken_id, output ready);
endinterface

`default_nettype wire

### hdl/stwq_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module stwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/semaphore_table_wait_queue.sv
// Table of SEM_COUNT counting semaphores, each with an owner, a signed 16-bit
// count, wrapping 32-bit up and down tallies and a FIFO wait queue of up to
// QUEUE_DEPTH caller ids. One request transfer on req gives exactly one
// response transfer on rsp. Allocate hands out the lowest free slot; free needs
// the owner and equal tallies; down queues the caller when the count is zero or
// below; up releases the queue head when the count is negative. The transfer
// cycle reads the slot record from the slot memory, and the execute state that
// follows modifies and writes it back. An up that releases a waiter also reads
// the wait-store memory before its response is loaded. The execute and release
// steps stall only while an earlier response still waits on rsp; a new request
// is taken while that response is pending. Both memories need no clearing after
// reset, since a slot record is only acted on once allocate has written it, so
// the block is ready right after reset.
`default_nettype none

`include "semaphore_table_wait_queue_assert.svh"

module semaphore_table_wait_queue import stwq_pkg::*; (
    input wire logic  clk,
    input wire logic  rst_n,
    stwq_req_if.sink  req,
    stwq_rsp_if.source rsp
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_WAKE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Request held for the execute cycle.
    func_t              op_reg;
    logic [3:0]         idx_reg;
    logic signed [15:0] init_reg;
    logic [CID_W-1:0]   caller_reg;

    // The used flags live in flip-flops so that allocate can search them at once.
    logic [SEM_COUNT-1:0] slot_used_reg, slot_used_next;

    // Response register.
    logic       out_valid_reg, out_valid_next;
    status_t    status_reg, status_next;
    logic [3:0] granted_reg, granted_next;
    logic       blocked_reg, blocked_next;
    logic       wvalid_reg, wvalid_next;
    logic [7:0] wid_reg, wid_next;

    // Slot memory ports.
    logic              slot_we;
    logic [SLOT_W-1:0] slot_waddr;
    slot_t             slot_wdata;
    logic              slot_re;
    logic [SLOT_W-1:0] slot_raddr;
    slot_t             slot_rdata;

    // Wait-store memory ports.
    logic               wait_we;
    logic [WAIT_AW-1:0] wait_waddr;
    logic               wait_re;
    logic [WAIT_AW-1:0] wait_raddr;
    logic [CID_W-1:0]   wait_rdata;

    logic              accept;
    logic              out_free;
    logic              exec_go;
    logic              is_wake;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.granted_index = granted_reg;
    assign rsp.caller_blocked = blocked_reg;
    assign rsp.woken_valid   = wvalid_reg;
    assign rsp.woken_id      = wid_reg;

    // The slot record is fetched in the transfer cycle and held for the execute state that follows.
    assign slot_re    = accept;
    assign slot_raddr = SLOT_W'(req.sem_index);

    stwq_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (SEM_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    stwq_ram #(
        .WIDTH (CID_W),
        .DEPTH (WAIT_DEPTH)
    ) u_wait_ram (
        .clk   (clk),
        .we    (wait_we),
        .waddr (wait_waddr),
        .wdata (caller_reg),
        .re    (wait_re),
        .raddr (wait_raddr),
        .rdata (wait_rdata)
    );

    // Lowest free slot: scanning down lets the lowest index win.
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SEM_COUNT - 1; i >= 0; i--)
        begin
            if (!slot_used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        logic [SLOT_W-1:0]  idx_s;
        logic               idx_ok;
        logic [16:0]        len;
        logic [HEAD_W:0]    pos_sum;
        logic [HEAD_W-1:0]  pos;
        logic [HEAD_W-1:0]  head_inc;
        logic [WAIT_AW-1:0] wait_base;
        logic               load_out;

        idx_s  = SLOT_W'(idx_reg);
        idx_ok = (32'(idx_reg) < 32'(SEM_COUNT)) && slot_used_reg[idx_s];

        // When the count is zero or below, its magnitude is the queue length.
        len     = -{slot_rdata.count[15], slot_rdata.count};
        pos_sum = {1'b0, slot_rdata.head} + (HEAD_W + 1)'(len);
        if (pos_sum >= (HEAD_W + 1)'(QUEUE_DEPTH))
        begin
            pos = HEAD_W'(pos_sum - (HEAD_W + 1)'(QUEUE_DEPTH));
        end
        else
        begin
            pos = HEAD_W'(pos_sum);
        end
        head_inc = (slot_rdata.head == HEAD_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : slot_rdata.head + 1'b1;
        wait_base = WAIT_AW'(WAIT_AW'(idx_s) * WAIT_AW'(QUEUE_DEPTH));

        is_wake = (op_reg == FN_UP) && idx_ok && slot_rdata.count[15];
        exec_go = (state_reg == S_EXEC) && (is_wake || out_free);

        state_next     = state_reg;
        slot_used_next = slot_used_reg;
        slot_we        = 1'b0;
        slot_waddr     = idx_s;
        slot_wdata     = slot_rdata;
        wait_we        = 1'b0;
        wait_waddr     = wait_base + WAIT_AW'(pos);
        wait_re        = 1'b0;
        wait_raddr     = wait_base + WAIT_AW'(slot_rdata.head);
        load_out       = 1'b0;

        status_next  = ST_OK;
        granted_next = '0;
        blocked_next = 1'b0;
        wvalid_next  = 1'b0;
        wid_next     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_go)
                begin
                    if (op_reg == FN_ALLOC)
                    begin
                        if (free_found)
                        begin
                            slot_we                  = 1'b1;
                            slot_waddr               = free_idx;
                            slot_wdata.owner         = caller_reg;
                            slot_wdata.count         = init_reg;
                            slot_wdata.up_tally      = '0;
                            slot_wdata.down_tally    = '0;
                            slot_wdata.head          = '0;
                            slot_used_next[free_idx] = 1'b1;
                            granted_next             = 4'(free_idx);
                        end
                        else
                        begin
                            status_next = ST_NONE_FREE;
                        end
                    end
                    else if (!idx_ok)
                    begin
                        status_next = ST_BAD_INDEX;
                    end
                    else
                    begin
                        unique case (op_reg)
                            FN_FREE:
                            begin
                                if (slot_rdata.owner != caller_reg)
                                begin
                                    status_next = ST_NOT_OWNER;
                                end
                                else if (slot_rdata.up_tally != slot_rdata.down_tally)
                                begin
                                    status_next = ST_TALLY;
                                end
                                else
                                begin
                                    slot_used_next[idx_s] = 1'b0;
                                end
                            end
                            FN_DOWN:
                            begin
                                if (slot_rdata.count <= 16'sd0
                                    && len >= 17'(QUEUE_DEPTH))
                                begin
                                    status_next = ST_QUEUE_FULL;
                                end
                                else
                                begin
                                    if (slot_rdata.count <= 16'sd0)
                                    begin
                                        wait_we      = 1'b1;
                                        blocked_next = 1'b1;
                                    end
                                    slot_we               = 1'b1;
                                    slot_wdata.count      = slot_rdata.count - 16'sd1;
                                    slot_wdata.down_tally = slot_rdata.down_tally + 32'd1;
                                end
                            end
                            default:
                            begin
                                // Up: release the head waiter when the count is
                                // negative; the count saturates at its maximum.
                                if (is_wake)
                                begin
                                    wait_re         = 1'b1;
                                    slot_wdata.head = head_inc;
                                end
                                if (slot_rdata.count != 16'sh7FFF)
                                begin
                                    slot_wdata.count = slot_rdata.count + 16'sd1;
                                end
                                slot_we             = 1'b1;
                                slot_wdata.up_tally = slot_rdata.up_tally + 32'd1;
                            end
                        endcase
                    end

                    if (is_wake)
                    begin
                        state_next = S_WAKE;
                    end
                    else
                    begin
                        load_out   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_WAKE:
            begin
                if (out_free)
                begin
                    wvalid_next = 1'b1;
                    wid_next    = 8'(wait_rdata);
                    load_out    = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = load_out || (out_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_used_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_used_reg <= slot_used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= req.func;
            idx_reg    <= req.sem_index;
            init_reg   <= req.initial_value;
            caller_reg <= CID_W'(req.caller_id);
        end
        if (out_valid_next && out_free)
        begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
            blocked_reg <= blocked_next;
            wvalid_reg  <= wvalid_next;
            wid_reg     <= wid_next;
        end
    end

    `STWQ_ASSERT(a_accept_then_exec, accept |=> (state_reg == S_EXEC), "request not executed")
    `STWQ_ASSERT(a_block_reports, wait_we |=> (rsp.valid && rsp.caller_blocked), "queued caller not reported")
    `STWQ_ASSERT(a_wake_reports, ((state_reg == S_WAKE) && out_free) |=> (rsp.valid && rsp.woken_valid), "release not reported")
    `STWQ_ASSERT(a_alloc_marks_used, (exec_go && (op_reg == FN_ALLOC) && free_found) |=> slot_used_reg[$past(free_idx)], "allocated slot not marked used")
    `STWQ_ASSERT_ALWAYS(a_no_write_on_fetch, !(slot_we && slot_re), "slot write overlaps slot fetch")

endmodule

`default_nettype wire
